// ===== design/fobl_pkg.sv =====
// Shared types and helpers for the fading overlay alpha blend core.
// Holds the pixel and result word structs, envelope info and the divide-by-255 helper.
// No dependencies.
package fobl_pkg;

  typedef struct packed {
    logic [7:0] screen_blue;
    logic [7:0] screen_green;
    logic [7:0] screen_red;
    logic [7:0] overlay_alpha;
    logic [7:0] overlay_blue;
    logic [7:0] overlay_green;
    logic [7:0] overlay_red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       overlay_active;
  } result_t;

  // Frame-level fade envelope as seen by the pixel pipeline
  typedef struct packed {
    logic       active;
    logic [7:0] env;
  } env_t;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_ELAPSED    = 2'd0;
  localparam logic [1:0] REG_LINE_START = 2'd1;
  localparam logic [1:0] REG_LINE_END   = 2'd2;

  // Exact floor(x / 255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

// ===== design/fobl_env.sv =====
// Fade envelope sequencer: derives the 0..255 envelope from the time registers.
// Recomputes after reset and after each register write, with a reciprocal multiply on a ramp.
// Depends on fobl_pkg.
module fobl_env
  import fobl_pkg::*;
#(
  parameter int FADE_MS = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        kick,
  input  logic [31:0] elapsed,
  input  logic [31:0] line_start,
  input  logic [31:0] line_end,
  output env_t        info,
  output logic        busy
);

  localparam int FADE_W  = $clog2(FADE_MS + 1);
  localparam int NUM_W   = FADE_W + 8;
  // floor(num / FADE_MS) as (num * RECIP) >> SHIFT, exact for num up to 255 * FADE_MS
  localparam int RECIP_W = FADE_W + 10;
  localparam int SHIFT   = 2 * FADE_W + 8;
  localparam int PROD_W  = NUM_W + RECIP_W;

  localparam logic signed [32:0] FADE_S = 33'(FADE_MS);
  localparam logic [63:0]        SCALE  = 64'd1 << SHIFT;
  localparam logic [RECIP_W-1:0] RECIP  =
    RECIP_W'((SCALE + 64'(FADE_MS) - 64'd1) / 64'(FADE_MS));

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0]        state;
  logic signed [32:0] diff_ts;
  logic signed [32:0] diff_et;
  logic [NUM_W-1:0]  dividend;

  logic              ramp_up;
  logic              full;
  logic              ramp_down;
  logic [FADE_W-1:0] span;
  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] product;

  always_comb begin
    ramp_up   = diff_ts < FADE_S;
    full      = !ramp_up && (diff_et > FADE_S);
    ramp_down = !ramp_up && !full && (diff_et > 33'sd0);
    // Before the start the ramp-up would go negative: clamp to zero
    if (ramp_up) begin
      span = diff_ts[32] ? '0 : diff_ts[FADE_W-1:0];
    end else begin
      span = diff_et[FADE_W-1:0];
    end
    num     = {span, 8'b0} - {8'b0, span};
    product = PROD_W'(dividend) * PROD_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CALC;
      info.active <= 1'b0;
      info.env    <= 8'd0;
    end else if (kick) begin
      state <= ST_CALC;
    end else begin
      case (state)
        ST_CALC: begin
          diff_ts <= $signed({1'b0, elapsed}) - $signed({1'b0, line_start});
          diff_et <= $signed({1'b0, line_end}) - $signed({1'b0, elapsed});
          state   <= ST_SEL;
        end
        ST_SEL: begin
          if (ramp_up || ramp_down) begin
            dividend <= num;
            state    <= ST_DIV;
          end else begin
            info.active <= full;
            info.env    <= full ? 8'd255 : 8'd0;
            state       <= ST_IDLE;
          end
        end
        ST_DIV: begin
          info.active <= 1'b1;
          info.env    <= product[SHIFT +: 8];
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = state != ST_IDLE;

endmodule

// ===== design/fading_overlay_alpha_blend_core.sv =====
// Top level of the fading overlay alpha blend core: APB registers and pixel pipeline.
// Depends on fobl_pkg and fobl_env.
//
// One pixel word per clock: a word is taken at each edge where start is high and busy is
// low, and its result appears on result with done high at the end of the pipeline; the
// receiver cannot stall, so the four-stage pixel pipeline (alpha product, alpha scaling,
// channel products, sum and divide by 255) never holds. busy is high only while the fade
// envelope is recomputed, after reset and after every register write: the times are
// subtracted and compared (states CALC and SEL), and on a ramp a further state (DIV) scales
// the offset by 255/FADE_MS with a reciprocal multiply.
module fading_overlay_alpha_blend_core
  import fobl_pkg::*;
#(
  parameter int FADE_MS = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pixel_t      pixel,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] elapsed;
  logic [31:0] line_start;
  logic [31:0] line_end;
  logic        cfg_write;
  env_t        info;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed    <= '0;
      line_start <= '0;
      line_end   <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_ELAPSED:    elapsed    <= pwdata;
        REG_LINE_START: line_start <= pwdata;
        REG_LINE_END:   line_end   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ELAPSED:    prdata = elapsed;
      REG_LINE_START: prdata = line_start;
      REG_LINE_END:   prdata = line_end;
      default:        prdata = '0;
    endcase
  end

  fobl_env #(
    .FADE_MS(FADE_MS)
  ) u_env (
    .clk       (clk),
    .rst       (rst),
    .kick      (cfg_write),
    .elapsed   (elapsed),
    .line_start(line_start),
    .line_end  (line_end),
    .info      (info),
    .busy      (busy)
  );

  // Pixel pipeline; a passed pixel has envelope 0, so the blend returns the screen as is
  logic        v1, v2, v3, v4;
  pixel_t      pix1, pix2;
  logic        act1, act2, act3;
  logic [15:0] alpha_prod;
  logic [7:0]  alpha;
  logic [15:0] ps_b, ps_g, ps_r;
  logic [15:0] po_b, po_g, po_r;
  logic [7:0]  inv_alpha;

  assign inv_alpha = 8'd255 - alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    pix1       <= pixel;
    act1       <= info.active;
    alpha_prod <= pixel.overlay_alpha * info.env;

    pix2  <= pix1;
    act2  <= act1;
    alpha <= div255(alpha_prod);

    act3 <= act2;
    ps_b <= pix2.screen_blue * inv_alpha;
    ps_g <= pix2.screen_green * inv_alpha;
    ps_r <= pix2.screen_red * inv_alpha;
    po_b <= pix2.overlay_blue * alpha;
    po_g <= pix2.overlay_green * alpha;
    po_r <= pix2.overlay_red * alpha;

    result.out_blue       <= div255(ps_b + po_b);
    result.out_green      <= div255(ps_g + po_g);
    result.out_red        <= div255(ps_r + po_r);
    result.overlay_active <= act3;
  end

  assign done = v4;

endmodule

// ===== design/fobl_checker.sv =====
// Port-level checker for the fading overlay alpha blend core, bound to the top level.
// Depends on fobl_pkg.
module fobl_checker
  import fobl_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input pixel_t  pixel,
  input logic    done,
  input result_t result,
  input logic    psel,
  input logic    penable,
  input logic    pwrite
);

  // Every accepted word comes out with done high at the end of the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##4 done)
    else $error("accepted word did not produce a result after four cycles");

  // No result without a matching accepted word
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without a matching accepted word");

  // A register write starts an envelope recompute
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> busy)
    else $error("register write did not raise busy");

  // A passed pixel is the screen pixel unchanged
  a_pass: assert property (@(posedge clk) disable iff (rst)
    done && !result.overlay_active |->
      result.out_blue == $past(pixel.screen_blue, 4) &&
      result.out_green == $past(pixel.screen_green, 4) &&
      result.out_red == $past(pixel.screen_red, 4))
    else $error("passed pixel differs from the screen pixel");

endmodule

bind fading_overlay_alpha_blend_core fobl_checker u_checker (.*);
